>>> sv/frm_pkg.sv
// Shared constants and types for the frame rate meter.
package frm_pkg;

	localparam int TS_W  = 64;
	localparam int FPS_W = 24;
	localparam int PER_W = 32;
	localparam int CFG_W = 32;
	localparam int MIX_W = 28;

	localparam logic [CFG_W-1:0] INTERVAL_RESET = 32'd250_000_000;
	localparam logic [TS_W-1:0]  NS_PER_MS      = 64'd1_000_000;
	localparam logic [TS_W-1:0]  RATE_SCALE     = 64'd256_000_000_000;
	localparam logic [FPS_W-1:0] MAX_FPS        = 24'hFF_FFFF;
	localparam logic [PER_W-1:0] MAX_PER        = 32'hFFFF_FFFF;

	localparam int               RECIP_SH = 32;
	localparam int               RECIP_W  = 29;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 29'd429_496_730;

	typedef logic [TS_W-1:0] ts_t;

endpackage

>>> sv/frm_ring.sv
// Timestamp ring memory with write slot and saturating fill count.
module frm_ring import frm_pkg::*; #(
	parameter int WINDOW = 60
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  ts_t                          wr_data,
	input  logic                         rd_en,
	output ts_t                          rd_data,
	output logic [$clog2(WINDOW+1)-1:0]  count
);

	localparam int SLOT_W = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);

	ts_t               mem [WINDOW];
	ts_t               rd_data_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] rd_addr;

	// The oldest entry sits at slot zero until the ring has wrapped.
	assign rd_addr = (count_q == CNT_W'(WINDOW)) ? slot_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
		end else if (wr_en) begin
			slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			if (count_q != CNT_W'(WINDOW)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign count   = count_q;

endmodule

>>> sv/frm_div.sv
// Bit-serial restoring divider with a truncated quotient window and an overflow flag.
module frm_div #(
	parameter int N_W = 64,
	parameter int D_W = 64,
	parameter int Q_W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           busy,
	output logic [Q_W-1:0] quotient,
	output logic [D_W-1:0] remainder,
	output logic           overflow
);

	localparam int CNT_W = $clog2(N_W);

	logic [N_W-1:0]   dvd_q;
	logic [D_W-1:0]   dsr_q;
	logic [D_W-1:0]   rem_q;
	logic [Q_W-1:0]   quo_q;
	logic             ovf_q;
	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W:0]     trial;
	logic [D_W+1:0]   diff;
	logic             take;

	assign trial = {rem_q, dvd_q[N_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dsr_q};
	assign take  = ~diff[D_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(N_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Quotient bits that leave the top of the window mark an overflow.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[N_W-2:0], 1'b0};
			rem_q <= take ? diff[D_W-1:0] : trial[D_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], take};
			ovf_q <= ovf_q | quo_q[Q_W-1];
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign overflow  = ovf_q;

endmodule

>>> sv/frm_ema.sv
// Two-stage exponential smoothing of the frame rate with rounding.
module frm_ema import frm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [FPS_W-1:0] avg_old,
	input  logic [FPS_W-1:0] rate_new,
	output logic             done,
	output logic [FPS_W-1:0] avg_new
);

	localparam int PROD_W = MIX_W + RECIP_W;

	logic                  v_s1;
	logic                  v_s2;
	logic [MIX_W-1:0]      mix_s1;
	logic                  seed_s1;
	logic [FPS_W-1:0]      rate_s1;
	logic [PROD_W-1:0]     prod_s2;
	logic                  seed_s2;
	logic [FPS_W-1:0]      rate_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
		end
	end

	// Division by ten is a multiply by its scaled reciprocal, exact below 2^30.
	always_ff @(posedge clk) begin
		mix_s1  <= MIX_W'(7) * MIX_W'(avg_old) + MIX_W'(3) * MIX_W'(rate_new) + MIX_W'(5);
		seed_s1 <= (avg_old == '0);
		rate_s1 <= rate_new;
		prod_s2 <= PROD_W'(mix_s1) * PROD_W'(RECIP_TEN);
		seed_s2 <= seed_s1;
		rate_s2 <= rate_s1;
	end

	assign done    = v_s2;
	assign avg_new = seed_s2 ? rate_s2 : prod_s2[RECIP_SH+FPS_W-1:RECIP_SH];

endmodule

>>> sv/frame_rate_meter_core.sv
// Top level of the frame rate meter: sequencer, rounding, held values and output register.
// A frame that does not publish passes from transfer through the elapsed and check states back to ready.
// A publishing frame with a measurement waits on the bit-serial divider that runs
// 80 steps on the frame period; the window rate divides in parallel in 64 steps.
// The result waits in an output register, so the next frame is taken while it is held.
// Reset clears the fill count, last publish time, held values and sets the interval to 250 ms.
module frame_rate_meter_core import frm_pkg::*; #(
	parameter int WINDOW = 60
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  ts_t              frame_timestamp,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [FPS_W-1:0] fps_smoothed,
	output logic [FPS_W-1:0] fps_window,
	output logic [PER_W-1:0] frame_period,
	output logic             fresh
);

	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int PN_W  = TS_W + 16;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ELAPSED,
		S_CHECK,
		S_SPAN,
		S_DIV,
		S_ROUND,
		S_MIX,
		S_EMA,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  interval_q;
	logic              started_q;
	ts_t               last_pub_q;
	logic [FPS_W-1:0]  held_s_q;
	logic [FPS_W-1:0]  held_w_q;
	logic [PER_W-1:0]  held_p_q;
	logic              fresh_q;
	logic              enough_q;
	logic              out_valid_q;
	logic [FPS_W-1:0]  out_s_q;
	logic [FPS_W-1:0]  out_w_q;
	logic [PER_W-1:0]  out_p_q;
	logic              out_f_q;

	ts_t               ts_q;
	ts_t               elapsed_q;
	logic [TS_W:0]     span_q;
	ts_t               num_q;
	ts_t               den_q;

	logic              in_xfer;
	logic              ring_rd;
	ts_t               ring_data;
	logic [CNT_W-1:0]  count;
	logic [CNT_W-1:0]  intervals;
	logic              measure;
	logic              div_go;
	logic              ema_go;

	logic              rate_busy;
	logic [FPS_W-1:0]  rate_quo;
	ts_t               rate_rem;
	logic              rate_ovf;
	logic              per_busy;
	logic [PER_W-1:0]  per_quo;
	ts_t               per_rem;
	logic              per_ovf;

	logic              rate_inc;
	logic              per_inc;
	logic [FPS_W:0]    rate_sum;
	logic [PER_W:0]    per_sum;
	logic              ema_done;
	logic [FPS_W-1:0]  ema_avg;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign ring_rd   = (state_q == S_ELAPSED);
	assign intervals = count - 1'b1;
	assign measure   = enough_q && !span_q[TS_W] && (span_q[TS_W-1:0] != '0);
	assign div_go    = (state_q == S_SPAN) && measure;
	assign ema_go    = (state_q == S_MIX);

	frm_ring #(.WINDOW(WINDOW)) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_xfer),
		.wr_data (frame_timestamp),
		.rd_en   (ring_rd),
		.rd_data (ring_data),
		.count   (count)
	);

	frm_div #(.N_W(TS_W), .D_W(TS_W), .Q_W(FPS_W)) u_rate_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go),
		.dividend  (num_q),
		.divisor   (span_q[TS_W-1:0]),
		.busy      (rate_busy),
		.quotient  (rate_quo),
		.remainder (rate_rem),
		.overflow  (rate_ovf)
	);

	frm_div #(.N_W(PN_W), .D_W(TS_W), .Q_W(PER_W)) u_per_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go),
		.dividend  ({span_q[TS_W-1:0], 16'h0000}),
		.divisor   (den_q),
		.busy      (per_busy),
		.quotient  (per_quo),
		.remainder (per_rem),
		.overflow  (per_ovf)
	);

	frm_ema u_ema (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (ema_go),
		.avg_old  (held_s_q),
		.rate_new (held_w_q),
		.done     (ema_done),
		.avg_new  (ema_avg)
	);

	// Round to nearest with ties up, then saturate to the output width.
	assign rate_inc = ({rate_rem, 1'b0} >= {1'b0, span_q[TS_W-1:0]});
	assign per_inc  = (({1'b0, per_rem} + {2'b00, den_q[TS_W-1:1]}) >= {1'b0, den_q});
	assign rate_sum = {1'b0, rate_quo} + (FPS_W + 1)'(rate_inc);
	assign per_sum  = {1'b0, per_quo} + (PER_W + 1)'(per_inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ts_q <= frame_timestamp;
		end
		if (state_q == S_ELAPSED) begin
			elapsed_q <= ts_q - last_pub_q;
		end
		if (state_q == S_CHECK) begin
			span_q <= {1'b0, ts_q} - {1'b0, ring_data};
			num_q  <= TS_W'(intervals) * RATE_SCALE;
			den_q  <= TS_W'(intervals) * NS_PER_MS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			started_q   <= 1'b0;
			last_pub_q  <= '0;
			held_s_q    <= '0;
			held_w_q    <= '0;
			held_p_q    <= '0;
			fresh_q     <= 1'b0;
			enough_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_s_q     <= '0;
			out_w_q     <= '0;
			out_p_q     <= '0;
			out_f_q     <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (!started_q) begin
							started_q  <= 1'b1;
							last_pub_q <= frame_timestamp;
						end
						state_q <= S_ELAPSED;
					end
				end
				S_ELAPSED: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (elapsed_q[TS_W-1:CFG_W] == '0 && elapsed_q[CFG_W-1:0] < interval_q) begin
						state_q <= S_IDLE;
					end else begin
						last_pub_q <= ts_q;
						enough_q   <= (count >= CNT_W'(2));
						state_q    <= S_SPAN;
					end
				end
				S_SPAN: begin
					if (measure) begin
						state_q <= S_DIV;
					end else begin
						fresh_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (!rate_busy && !per_busy) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					held_w_q <= (rate_ovf || rate_sum[FPS_W]) ? MAX_FPS : rate_sum[FPS_W-1:0];
					held_p_q <= (per_ovf || per_sum[PER_W]) ? MAX_PER : per_sum[PER_W-1:0];
					state_q  <= S_MIX;
				end
				S_MIX: begin
					state_q <= S_EMA;
				end
				S_EMA: begin
					if (ema_done) begin
						held_s_q <= ema_avg;
						fresh_q  <= 1'b1;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_s_q     <= held_s_q;
						out_w_q     <= held_w_q;
						out_p_q     <= held_p_q;
						out_f_q     <= fresh_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign fps_smoothed = out_s_q;
	assign fps_window   = out_w_q;
	assign frame_period = out_p_q;
	assign fresh        = out_f_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(WINDOW))
		else $error("Fill count exceeds the window depth.");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |=> (rate_busy && per_busy && state_q == S_DIV))
		else $error("Dividers did not start together.");

	a_div_order: assert property (@(posedge clk) disable iff (!arst_n)
		rate_busy |-> per_busy)
		else $error("Rate divider outlasted the period divider.");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rate_busy || per_busy || ema_done) |-> !in_ready)
		else $error("Input ready while a measurement is in progress.");

endmodule
